// ===== src/i2cm_pkg.sv =====
// Package for the I2C master byte engine: operation codes, sequencer phases,
// register map and field widths. Depends on nothing.
package i2cm_pkg;

  // Field widths of the command and result transfers.
  localparam int OpW   = 3;
  localparam int ByteW = 8;

  // Operation codes carried by the command channel.
  typedef enum logic [OpW-1:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  // Sequencer phases, one-hot.
  typedef enum logic [17:0] {
    PH_IDLE  = 18'h00001,
    PH_S1    = 18'h00002,
    PH_S2    = 18'h00004,
    PH_S3    = 18'h00008,
    PH_S4    = 18'h00010,
    PH_P1    = 18'h00020,
    PH_P2    = 18'h00040,
    PH_P3    = 18'h00080,
    PH_WBIT  = 18'h00100,
    PH_WHIGH = 18'h00200,
    PH_WLOW  = 18'h00400,
    PH_WREL  = 18'h00800,
    PH_WCLK  = 18'h01000,
    PH_WWAIT = 18'h02000,
    PH_RREL  = 18'h04000,
    PH_RHIGH = 18'h08000,
    PH_RSAMP = 18'h10000,
    PH_RLOW  = 18'h20000
  } phase_t;

  // Configuration register map: one register per 32-bit word.
  localparam int PaddrW = 3;
  localparam logic REG_ACK_TIMEOUT = 1'b0;

  // Reset value of the ACK timeout and the number of bits in a byte.
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd200;
  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

endpackage

// ===== src/i2cm_cmd_if.sv =====
// Command channel of the I2C master byte engine: valid/ready plus one bus tick.
// Depends on i2cm_pkg for the field widths.
interface i2cm_cmd_if import i2cm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   operation;
  logic [ByteW-1:0] write_byte;
  logic             sda_in;

  modport source (output valid, operation, write_byte, sda_in, input ready);
  modport sink   (input valid, operation, write_byte, sda_in, output ready);
endinterface

// ===== src/i2cm_res_if.sv =====
// Result channel of the I2C master byte engine: valid/ready plus line levels
// and status for one tick. Depends on i2cm_pkg for the field widths.
interface i2cm_res_if import i2cm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             scl_out;
  logic             sda_out;
  logic             busy_res;
  logic             done_res;
  logic             ack_ok;
  logic [ByteW-1:0] read_data;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, ack_ok, read_data,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, ack_ok, read_data,
                  output ready);
endinterface

// ===== src/i2c_master_byte_engine.sv =====
// Top level of the I2C master byte engine: tick sequencer, ACK timeout register
// and result register. Depends on i2cm_pkg, i2cm_cmd_if and i2cm_res_if.
//
//   Channel  Direction  Handshake              Contents
//   cmd      in         valid/ready            operation, write_byte, sda_in
//   res      out        valid/ready            scl_out, sda_out, busy_res, done_res,
//                                              ack_ok, read_data
//   APB      in         psel/penable/pready    ack_timeout at byte address 0
//
// One command transfer is one bus tick; the sequencer advances one phase per tick,
// so a tick is taken every cycle while cmd.ready is high, with its result in the
// next cycle. The result register is the only stage: cmd.ready drops only while
// a result waits and res.ready is low. Reset (rst, synchronous) returns the
// sequencer to idle, both lines released, read_data at zero, ack_timeout at 200.
module i2c_master_byte_engine import i2cm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  i2cm_cmd_if.sink             cmd,
  i2cm_res_if.source           res,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrW-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // Sequencer state.
  phase_t           phase, phase_next;
  logic [3:0]       bit_count, bit_count_next;
  logic [7:0]       shift_reg, shift_reg_next;
  logic [7:0]       wait_count, wait_count_next;
  logic             scl_level, scl_level_next;
  logic             sda_level, sda_level_next;
  logic [7:0]       read_hold, read_hold_next;
  logic [7:0]       ack_timeout;
  logic             done_next;
  logic             ack_next;
  logic             cmd_xfer;

  // Configuration port: always ready, one register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= ACK_TIMEOUT_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_ACK_TIMEOUT) begin
      ack_timeout <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ACK_TIMEOUT) begin
      prdata = {24'd0, ack_timeout};
    end
  end

  // A tick is taken whenever the result register is free or being drained.
  assign cmd.ready = !res.valid || res.ready;
  assign cmd_xfer  = cmd.valid && cmd.ready;

  // Next state for one tick: an idle sequencer first picks up the command,
  // then the current phase performs its single line action.
  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    wait_count_next = wait_count;
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;
    read_hold_next  = read_hold;
    done_next       = 1'b0;
    ack_next        = 1'b0;

    if (phase == PH_IDLE) begin
      bit_count_next  = '0;
      wait_count_next = '0;
      case (op_t'(cmd.operation))
        OP_START: phase_next = PH_S1;
        OP_STOP:  phase_next = PH_P1;
        OP_WRITE: begin
          shift_reg_next = cmd.write_byte;
          phase_next     = PH_WBIT;
        end
        OP_READ: begin
          shift_reg_next = '0;
          phase_next     = PH_RREL;
        end
        default: phase_next = PH_IDLE;
      endcase
    end

    unique case (phase_next)
      PH_IDLE: phase_next = PH_IDLE;
      PH_S1: begin
        sda_level_next = 1'b1;
        phase_next     = PH_S2;
      end
      PH_S2: begin
        scl_level_next = 1'b1;
        phase_next     = PH_S3;
      end
      PH_S3: begin
        sda_level_next = 1'b0;
        phase_next     = PH_S4;
      end
      PH_S4: begin
        scl_level_next = 1'b0;
        phase_next     = PH_IDLE;
        done_next      = 1'b1;
      end
      PH_P1: begin
        sda_level_next = 1'b0;
        phase_next     = PH_P2;
      end
      PH_P2: begin
        scl_level_next = 1'b1;
        phase_next     = PH_P3;
      end
      PH_P3: begin
        sda_level_next = 1'b1;
        phase_next     = PH_IDLE;
        done_next      = 1'b1;
      end
      // Write: present the next bit, then clock it out.
      PH_WBIT: begin
        sda_level_next = shift_reg_next[7];
        shift_reg_next = {shift_reg_next[6:0], 1'b0};
        phase_next     = PH_WHIGH;
      end
      PH_WHIGH: begin
        scl_level_next = 1'b1;
        phase_next     = PH_WLOW;
      end
      PH_WLOW: begin
        scl_level_next = 1'b0;
        bit_count_next = bit_count_next + 4'd1;
        phase_next     = (bit_count_next >= BITS_PER_BYTE) ? PH_WREL : PH_WBIT;
      end
      PH_WREL: begin
        sda_level_next = 1'b1;
        phase_next     = PH_WCLK;
      end
      PH_WCLK: begin
        scl_level_next  = 1'b1;
        wait_count_next = '0;
        phase_next      = PH_WWAIT;
      end
      // Wait for the slave to pull SDA low, or give up after the timeout.
      PH_WWAIT: begin
        if (!cmd.sda_in) begin
          scl_level_next = 1'b0;
          phase_next     = PH_IDLE;
          done_next      = 1'b1;
          ack_next       = 1'b1;
        end else if (wait_count_next >= ack_timeout) begin
          scl_level_next = 1'b0;
          phase_next     = PH_IDLE;
          done_next      = 1'b1;
        end else begin
          wait_count_next = wait_count_next + 8'd1;
        end
      end
      // Read: release SDA once, then clock in eight bits.
      PH_RREL: begin
        sda_level_next = 1'b1;
        phase_next     = PH_RHIGH;
      end
      PH_RHIGH: begin
        scl_level_next = 1'b1;
        phase_next     = PH_RSAMP;
      end
      PH_RSAMP: begin
        shift_reg_next = {shift_reg_next[6:0], cmd.sda_in};
        phase_next     = PH_RLOW;
      end
      PH_RLOW: begin
        scl_level_next = 1'b0;
        bit_count_next = bit_count_next + 4'd1;
        if (bit_count_next >= BITS_PER_BYTE) begin
          read_hold_next = shift_reg_next;
          phase_next     = PH_IDLE;
          done_next      = 1'b1;
        end else begin
          phase_next = PH_RHIGH;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // Sequencer registers advance once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= '0;
      shift_reg  <= '0;
      wait_count <= '0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      read_hold  <= '0;
    end else if (cmd_xfer) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_reg  <= shift_reg_next;
      wait_count <= wait_count_next;
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
      read_hold  <= read_hold_next;
    end
  end

  // Result register: valid is control, the fields load with each tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (cmd_xfer) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      res.scl_out   <= scl_level_next;
      res.sda_out   <= sda_level_next;
      res.busy_res  <= (phase_next != PH_IDLE);
      res.done_res  <= done_next;
      res.ack_ok    <= ack_next;
      res.read_data <= read_hold_next;
    end
  end

endmodule

// ===== dv/i2c_master_byte_engine_test.sv =====
`timescale 1ns / 1ps
// Testbench for the I2C master byte engine: directed and random bus ticks, each result
// checked against a tick-exact model of the SCL/SDA sequencer kept in this file.
// Depends on i2cm_pkg, i2cm_cmd_if, i2cm_res_if and i2c_master_byte_engine.
module i2c_master_byte_engine_test;
  import i2cm_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [PaddrW-1:0] TIMEOUT_ADDR = PaddrW'(4 * REG_ACK_TIMEOUT);

  // One tick on the command channel and the line status it produces.
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [ByteW-1:0] wbyte;
    logic             sda_in;
  } bus_tick_t;

  typedef struct packed {
    logic             scl, sda, busy, done, ack;
    logic [ByteW-1:0] rdata;
  } line_status_t;

  // Sequencer state together with the ACK timeout setting.
  typedef struct {
    phase_t           ph;
    logic [3:0]       bits;
    logic [ByteW-1:0] shreg;
    logic [7:0]       waits;
    logic             scl;
    logic             sda;
    logic [ByteW-1:0] rd_hold;
    logic [7:0]       ack_limit;
  } sequencer_t;

  // Levels that the slave presents on SDA while a read samples it.
  typedef enum int {RD_ZEROS, RD_ONES, RD_RANDOM} read_pattern_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel, penable, pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata, prdata;
  logic              pready;

  i2cm_cmd_if cmd_ch ();
  i2cm_res_if res_ch ();

  i2c_master_byte_engine dut (
    .clk, .rst, .cmd(cmd_ch), .res(res_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Ticks waiting to be sent, and line status due back, oldest first.
  bus_tick_t    tick_queue[$];
  line_status_t line_levels_due[$];

  // sched_bus runs ahead while ticks are queued; bus_now follows accepted transfers.
  sequencer_t sched_bus, bus_now;
  int         work_ticks = 0;
  int         fail_count = 0;
  int         tx_gap_max = 0, rx_gap_max = 0;
  int         tx_gap = 0, rx_stall = 0, quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_sequencer(output sequencer_t s);
    s.ph        = PH_IDLE;
    s.bits      = '0;
    s.shreg     = '0;
    s.waits     = '0;
    s.scl       = 1'b1;
    s.sda       = 1'b1;
    s.rd_hold   = '0;
    s.ack_limit = ACK_TIMEOUT_RST;
  endfunction

  // One bus tick: start a command when idle, then take exactly one line action.
  function automatic void advance_bus(inout sequencer_t s, input bus_tick_t t,
                                      output line_status_t r);
    logic done_now, ack_now;
    done_now = 1'b0;
    ack_now  = 1'b0;
    if (s.ph == PH_IDLE) begin
      s.bits  = '0;
      s.waits = '0;
      case (t.op)
        OP_START: s.ph = PH_S1;
        OP_STOP:  s.ph = PH_P1;
        OP_WRITE: begin
          s.shreg = t.wbyte;
          s.ph    = PH_WBIT;
        end
        OP_READ: begin
          s.shreg = '0;
          s.ph    = PH_RREL;
        end
        default: ;
      endcase
    end

    case (s.ph)
      PH_S1: begin s.sda = 1'b1; s.ph = PH_S2; end
      PH_S2: begin s.scl = 1'b1; s.ph = PH_S3; end
      PH_S3: begin s.sda = 1'b0; s.ph = PH_S4; end
      PH_S4: begin s.scl = 1'b0; s.ph = PH_IDLE; done_now = 1'b1; end
      PH_P1: begin s.sda = 1'b0; s.ph = PH_P2; end
      PH_P2: begin s.scl = 1'b1; s.ph = PH_P3; end
      PH_P3: begin s.sda = 1'b1; s.ph = PH_IDLE; done_now = 1'b1; end
      PH_WBIT: begin
        s.sda   = s.shreg[ByteW-1];
        s.shreg = s.shreg << 1;
        s.ph    = PH_WHIGH;
      end
      PH_WHIGH: begin s.scl = 1'b1; s.ph = PH_WLOW; end
      PH_WLOW: begin
        s.scl  = 1'b0;
        s.bits = s.bits + 4'd1;
        if (s.bits >= BITS_PER_BYTE) s.ph = PH_WREL;
        else s.ph = PH_WBIT;
      end
      PH_WREL: begin s.sda = 1'b1; s.ph = PH_WCLK; end
      PH_WCLK: begin s.scl = 1'b1; s.waits = '0; s.ph = PH_WWAIT; end
      PH_WWAIT: begin
        // The slave pulls SDA low to acknowledge; otherwise count failed samples.
        if (t.sda_in == 1'b0) begin
          s.scl    = 1'b0;
          s.ph     = PH_IDLE;
          done_now = 1'b1;
          ack_now  = 1'b1;
        end else if (s.waits >= s.ack_limit) begin
          s.scl    = 1'b0;
          s.ph     = PH_IDLE;
          done_now = 1'b1;
        end else begin
          s.waits = s.waits + 8'd1;
        end
      end
      PH_RREL:  begin s.sda = 1'b1; s.ph = PH_RHIGH; end
      PH_RHIGH: begin s.scl = 1'b1; s.ph = PH_RSAMP; end
      PH_RSAMP: begin
        s.shreg = {s.shreg[ByteW-2:0], t.sda_in};
        s.ph    = PH_RLOW;
      end
      PH_RLOW: begin
        s.scl  = 1'b0;
        s.bits = s.bits + 4'd1;
        if (s.bits >= BITS_PER_BYTE) begin
          s.rd_hold = s.shreg;
          s.ph      = PH_IDLE;
          done_now  = 1'b1;
        end else begin
          s.ph = PH_RHIGH;
        end
      end
      default: s.ph = PH_IDLE;
    endcase

    r.scl   = s.scl;
    r.sda   = s.sda;
    r.busy  = (s.ph != PH_IDLE);
    r.done  = done_now;
    r.ack   = ack_now;
    r.rdata = s.rd_hold;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Queue one command and then ticks until it finishes. Ticks after the first carry random
  // operations, which the engine ignores while busy. SDA follows the slave's planned answer.
  function automatic void send_cmd(input logic [OpW-1:0] op, input logic [ByteW-1:0] wb,
                                   input bit nack, input int ack_at,
                                   input read_pattern_t rd);
    bus_tick_t    t;
    line_status_t st;
    bit           first;
    first = 1'b1;
    do begin
      t.op    = first ? op : OpW'($urandom_range(0, (1 << OpW) - 1));
      t.wbyte = first ? wb : ByteW'($urandom);
      if (sched_bus.ph == PH_WWAIT)
        t.sda_in = (nack || int'(sched_bus.waits) < ack_at);
      else if (sched_bus.ph == PH_RSAMP)
        t.sda_in = (rd == RD_RANDOM) ? 1'($urandom) : (rd == RD_ONES);
      else
        t.sda_in = 1'($urandom);
      advance_bus(sched_bus, t, st);
      if (st.busy || st.done) work_ticks++;
      tick_queue.push_back(t);
      first = 1'b0;
    end while (sched_bus.ph != PH_IDLE);
  endfunction

  function automatic void send_write(input logic [ByteW-1:0] wb);
    send_cmd(OP_WRITE, wb, $urandom_range(0, 7) == 0, $urandom_range(0, 3), RD_RANDOM);
  endfunction

  // A well-formed transaction: start, address byte, one to four data bytes read or written, usually a stop.
  function automatic void bus_transaction();
    send_cmd(OP_START, ByteW'($urandom), 1'b0, 0, RD_RANDOM);
    send_write(ByteW'($urandom));
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 1) == 1) send_write(ByteW'($urandom));
      else send_cmd(OP_READ, ByteW'($urandom), 1'b0, 0, RD_RANDOM);
    end
    if ($urandom_range(0, 4) != 0) send_cmd(OP_STOP, ByteW'($urandom), 1'b0, 0, RD_RANDOM);
  endfunction

  // Wait until every queued tick is sent and every result is back, then let the engine settle.
  task automatic drain();
    do @(negedge clk);
    while (tick_queue.size() != 0 || cmd_ch.valid || line_levels_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Optionally write the ACK timeout, then read it back over the same port.
  task automatic program_timeout(input bit write_first, input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_first;
    paddr   <= TIMEOUT_ADDR;
    pwdata  <= 32'(value);
    if (write_first) begin
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sched_bus.ack_limit = value;
      bus_now.ack_limit   = value;
    end
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    check_field("ack_timeout", value, prdata[7:0]);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random traffic, mostly well-formed transactions. The sender stops once halfway until
  // every expected result has come back.
  task automatic random_traffic(input int amount);
    int goal, halfway;
    bit paused;
    goal    = work_ticks + amount;
    halfway = work_ticks + amount / 2;
    paused  = 1'b0;
    while (work_ticks < goal) begin
      if ($urandom_range(0, 9) < 8)
        bus_transaction();
      else
        send_cmd(OpW'($urandom_range(0, (1 << OpW) - 1)), ByteW'($urandom), 1'($urandom),
                 $urandom_range(0, 3), RD_RANDOM);
      if (!paused && work_ticks >= halfway) begin
        drain();
        paused = 1'b1;
      end
    end
    drain();
  endtask

  // Command driver: predict each tick transfer as it is taken, then present the next one.
  always @(posedge clk) begin : cmd_driver
    bus_tick_t    taken, nxt;
    line_status_t due;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      tx_gap       <= 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        taken = {cmd_ch.operation, cmd_ch.write_byte, cmd_ch.sda_in};
        advance_bus(bus_now, taken, due);
        line_levels_due.push_back(due);
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (tx_gap != 0) begin
          tx_gap       <= tx_gap - 1;
          cmd_ch.valid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          nxt = tick_queue.pop_front();
          cmd_ch.operation  <= nxt.op;
          cmd_ch.write_byte <= nxt.wbyte;
          cmd_ch.sda_in     <= nxt.sda_in;
          cmd_ch.valid      <= 1'b1;
          tx_gap            <= $urandom_range(0, tx_gap_max);
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expectation, then stall at random.
  always @(posedge clk) begin : res_monitor
    line_status_t want;
    int           stall;
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_stall     <= 0;
    end else if (res_ch.valid && res_ch.ready) begin
      if (line_levels_due.size() == 0) begin
        $error("result transfer with no expected result waiting");
        fail_count++;
      end else begin
        want = line_levels_due.pop_front();
        check_field("scl_out", 8'(want.scl), 8'(res_ch.scl_out));
        check_field("sda_out", 8'(want.sda), 8'(res_ch.sda_out));
        check_field("busy_res", 8'(want.busy), 8'(res_ch.busy_res));
        check_field("done_res", 8'(want.done), 8'(res_ch.done_res));
        check_field("ack_ok", 8'(want.ack), 8'(res_ch.ack_ok));
        check_field("read_data", want.rdata, res_ch.read_data);
      end
      stall = $urandom_range(0, rx_gap_max);
      if (stall == 0) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b0;
        rx_stall     <= stall - 1;
      end
    end else if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Watchdog: end the run when no transfer happens on either channel for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("i2c_master_byte_engine_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.operation  = OP_TICK;
    cmd_ch.write_byte = '0;
    cmd_ch.sda_in     = 1'b1;
    res_ch.ready      = 1'b0;
    reset_sequencer(sched_bus);
    reset_sequencer(bus_now);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset timeout: idle ticks on every unused code, data extremes,
    // an ACK timeout, repeated start and a stop with the bus already free.
    program_timeout(1'b0, ACK_TIMEOUT_RST);
    tx_gap_max = 3;
    rx_gap_max = 3;
    send_cmd(OP_TICK, 8'h00, 1'b0, 0, RD_RANDOM);
    for (int code = int'(OP_READ) + 1; code < (1 << OpW); code++)
      send_cmd(OpW'(code), 8'hFF, 1'b0, 0, RD_RANDOM);
    send_cmd(OP_START, 8'h00, 1'b0, 0, RD_RANDOM);
    send_cmd(OP_WRITE, 8'hA5, 1'b0, 0, RD_RANDOM);
    send_cmd(OP_WRITE, 8'hFF, 1'b0, 3, RD_RANDOM);
    send_cmd(OP_WRITE, 8'h00, 1'b1, 0, RD_RANDOM);
    send_cmd(OP_READ, 8'h00, 1'b0, 0, RD_ONES);
    send_cmd(OP_READ, 8'hFF, 1'b0, 0, RD_ZEROS);
    send_cmd(OP_START, 8'h00, 1'b0, 0, RD_RANDOM);
    send_cmd(OP_READ, 8'h00, 1'b0, 0, RD_RANDOM);
    send_cmd(OP_STOP, 8'h00, 1'b0, 0, RD_RANDOM);
    send_cmd(OP_STOP, 8'hFF, 1'b0, 0, RD_RANDOM);
    drain();

    // Zero timeout: a write fails on its first high sample.
    program_timeout(1'b1, 8'd0);
    tx_gap_max = 14;
    rx_gap_max = 14;
    send_cmd(OP_START, 8'h00, 1'b0, 0, RD_RANDOM);
    send_cmd(OP_WRITE, 8'h5A, 1'b1, 0, RD_RANDOM);
    send_cmd(OP_WRITE, 8'h3C, 1'b0, 0, RD_RANDOM);
    send_cmd(OP_STOP, 8'h00, 1'b0, 0, RD_RANDOM);
    random_traffic(60);

    // Longest timeout, with no idling on either side.
    program_timeout(1'b1, 8'd255);
    tx_gap_max = 0;
    rx_gap_max = 0;
    random_traffic(60);

    // Timeout of one: late ACKs turn into failures.
    program_timeout(1'b1, 8'd1);
    tx_gap_max = 14;
    rx_gap_max = 0;
    random_traffic(60);

    program_timeout(1'b1, 8'($urandom_range(2, 254)));
    tx_gap_max = 0;
    rx_gap_max = 14;
    random_traffic(60);

    if (fail_count == 0)
      $display("i2c_master_byte_engine_test: clean");
    else
      $display("i2c_master_byte_engine_test: errors");
    $finish;
  end

endmodule

// ===== files.f =====
src/i2cm_pkg.sv
src/i2cm_cmd_if.sv
src/i2cm_res_if.sv
src/i2c_master_byte_engine.sv
dv/i2c_master_byte_engine_test.sv
